### rtl/core/amf0_stream_tokenizer_unit_assert.svh
// Assertion macros shared by the AMF0 tokenizer RTL.
// Included by modules that carry concurrent assertions.
`ifndef AMF0_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define AMF0_STREAM_TOKENIZER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AMF0_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define AMF0_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/amf0_pkg.sv
// Package for the AMF0 stream tokenizer: payload types, codes, constants.
// No dependencies.
package amf0_pkg;

    localparam int DEPTH_W = 5;
    localparam int MAX_DEPTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        KIND_IGNORED  = 4'd0,
        KIND_MARKER   = 4'd1,
        KIND_NUMBER   = 4'd2,
        KIND_BOOLEAN  = 4'd3,
        KIND_STR_LEN  = 4'd4,
        KIND_STR_DATA = 4'd5,
        KIND_KEY_LEN  = 4'd6,
        KIND_KEY_DATA = 4'd7,
        KIND_OBJ_END  = 4'd8,
        KIND_ERROR    = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MARKER    = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_TOO_DEEP  = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        PH_MARKER  = 4'd0,
        PH_NUM     = 4'd1,
        PH_BOOL    = 4'd2,
        PH_SLEN_HI = 4'd3,
        PH_SLEN_LO = 4'd4,
        PH_SDATA   = 4'd5,
        PH_KLEN_HI = 4'd6,
        PH_KLEN_LO = 4'd7,
        PH_KDATA   = 4'd8,
        PH_IDLE    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        MC_NUMBER  = 3'd0,
        MC_BOOLEAN = 3'd1,
        MC_STRING  = 3'd2,
        MC_OBJECT  = 3'd3,
        MC_NULL    = 3'd4,
        MC_END     = 3'd5,
        MC_UNKNOWN = 3'd6
    } mclass_t;

    localparam logic [7:0] MARK_NUMBER  = 8'h00;
    localparam logic [7:0] MARK_BOOLEAN = 8'h01;
    localparam logic [7:0] MARK_STRING  = 8'h02;
    localparam logic [7:0] MARK_OBJECT  = 8'h03;
    localparam logic [7:0] MARK_NULL    = 8'h05;
    localparam logic [7:0] MARK_OBJ_END = 8'h09;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  byte_kind;
        logic [7:0]  byte_value;
        logic [4:0]  nest_depth;
        logic [63:0] number_bits;
        logic        number_done;
        logic        bool_value;
        logic [15:0] field_length;
        logic        value_done;
        logic [1:0]  error_code;
        logic        message_done;
    } out_item_t;

    // Classified byte passed from front to back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        mclass_t    mclass;
        logic       is_zero;
    } tok_t;

    function automatic mclass_t classify(input logic [7:0] b);
        mclass_t c;
        case (b)
            MARK_NUMBER:  c = MC_NUMBER;
            MARK_BOOLEAN: c = MC_BOOLEAN;
            MARK_STRING:  c = MC_STRING;
            MARK_OBJECT:  c = MC_OBJECT;
            MARK_NULL:    c = MC_NULL;
            MARK_OBJ_END: c = MC_END;
            default:      c = MC_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/amf0_front.sv
// Front stage: accepts input bytes, classifies the marker code, and
// pushes tokens into a short queue. Depends on amf0_pkg.
module amf0_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  amf0_pkg::in_item_t in_data,
    output logic              tok_valid,
    input  logic              tok_pop,
    output amf0_pkg::tok_t    tok_data
);
    import amf0_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    tok_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             push;
    tok_t             tok_new;

    assign in_stall  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign tok_valid = (cnt_reg != '0);
    assign tok_data  = q_reg[rd_reg];

    always_comb
    begin
        tok_new.data_byte  = in_data.data_byte;
        tok_new.first_byte = in_data.first_byte;
        tok_new.last_byte  = in_data.last_byte;
        tok_new.mclass     = classify(in_data.data_byte);
        tok_new.is_zero    = (in_data.data_byte == 8'd0);
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = tok_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(tok_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= tok_new;
        end
    end

endmodule

### rtl/core/amf0_back.sv
// Back stage: runs the parse state machine on queued tokens and holds
// the registered result. Depends on amf0_pkg and the assertion header.
`include "amf0_stream_tokenizer_unit_assert.svh"
module amf0_back #(
    parameter int MAX_DEPTH = amf0_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_pop,
    input  amf0_pkg::tok_t      tok_data,
    output logic                out_valid,
    input  logic                out_stall,
    output amf0_pkg::out_item_t out_data
);
    import amf0_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  depth_reg, depth_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  lhi_reg, lhi_next;
    logic [63:0] shift_reg, shift_next;
    logic        ek_reg, ek_next;
    err_t        err_reg, err_next;
    logic        valid_reg;
    out_item_t   out_reg, res;
    logic        vf;
    logic [15:0] fl;
    logic [15:0] left_dec;

    assign tok_pop   = tok_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        phase_t p;
        logic [4:0] d;
        logic [15:0] l;
        logic [7:0] h;
        logic [63:0] s;
        logic e;
        err_t er;
        kind_t k;
        logic nd, bv, vd;
        logic [63:0] nb;
        p  = phase_reg; d = depth_reg; l = left_reg; h = lhi_reg;
        s  = shift_reg; e = ek_reg; er = err_reg;
        if (tok_data.first_byte)
        begin
            p = PH_MARKER; d = '0; l = '0; h = '0; s = '0; e = 1'b0; er = ERR_NONE;
        end
        k = KIND_IGNORED; nd = 1'b0; bv = 1'b0; vd = 1'b0; nb = '0; fl = '0; vf = 1'b0;
        left_dec = (l != 16'd0) ? l - 16'd1 : l;
        res = '0;
        res.byte_value = tok_data.data_byte;
        if (p == PH_IDLE)
        begin
            phase_next = p; depth_next = d; left_next = l; lhi_next = h;
            shift_next = s; ek_next = e; err_next = er;
        end
        else
        begin
            if (er == ERR_NONE)
            begin
                case (p)
                    PH_MARKER:
                    begin
                        if (e && tok_data.mclass == MC_END)
                        begin
                            k = KIND_OBJ_END; e = 1'b0;
                            if (d != '0) d = d - 5'd1;
                            vf = 1'b1;
                        end
                        else
                        begin
                            e = 1'b0; k = KIND_MARKER;
                            case (tok_data.mclass)
                                MC_NUMBER:  begin l = 16'd8; s = '0; p = PH_NUM; end
                                MC_BOOLEAN: p = PH_BOOL;
                                MC_STRING:  p = PH_SLEN_HI;
                                MC_OBJECT:
                                begin
                                    if (d >= 5'(MAX_DEPTH)) er = ERR_TOO_DEEP;
                                    else begin d = d + 5'd1; p = PH_KLEN_HI; end
                                end
                                MC_NULL:    vf = 1'b1;
                                default:    er = ERR_MARKER;
                            endcase
                        end
                    end
                    PH_NUM:
                    begin
                        k = KIND_NUMBER;
                        s = {s[55:0], tok_data.data_byte};
                        l = left_dec;
                        if (l == 16'd0) begin nd = 1'b1; nb = s; vf = 1'b1; end
                    end
                    PH_BOOL:
                    begin
                        k = KIND_BOOLEAN; bv = !tok_data.is_zero; vf = 1'b1;
                    end
                    PH_SLEN_HI: begin k = KIND_STR_LEN; h = tok_data.data_byte; p = PH_SLEN_LO; end
                    PH_SLEN_LO:
                    begin
                        k = KIND_STR_LEN; fl = {h, tok_data.data_byte};
                        if (fl == 16'd0) vf = 1'b1;
                        else begin l = fl; p = PH_SDATA; end
                    end
                    PH_SDATA:
                    begin
                        k = KIND_STR_DATA; l = left_dec;
                        if (l == 16'd0) vf = 1'b1;
                    end
                    PH_KLEN_HI: begin k = KIND_KEY_LEN; h = tok_data.data_byte; p = PH_KLEN_LO; end
                    PH_KLEN_LO:
                    begin
                        k = KIND_KEY_LEN; fl = {h, tok_data.data_byte};
                        if (fl == 16'd0) begin e = 1'b1; p = PH_MARKER; end
                        else begin l = fl; p = PH_KDATA; end
                    end
                    PH_KDATA:
                    begin
                        k = KIND_KEY_DATA; l = left_dec;
                        if (l == 16'd0) p = PH_MARKER;
                    end
                    default: p = PH_MARKER;
                endcase
                // Close the value: top level returns to marker, inside an object to a key.
                if (vf)
                begin
                    if (d == '0) begin p = PH_MARKER; vd = 1'b1; end
                    else p = PH_KLEN_HI;
                end
            end
            if (tok_data.last_byte && er == ERR_NONE && !(p == PH_MARKER && d == '0))
                er = ERR_TRUNCATED;
            if (er != ERR_NONE)
            begin
                k = KIND_ERROR; nb = '0; nd = 1'b0; bv = 1'b0; fl = '0; vd = 1'b0;
            end
            res.byte_kind    = k;
            res.nest_depth   = d;
            res.number_bits  = nb;
            res.number_done  = nd;
            res.bool_value   = bv;
            res.field_length = fl;
            res.value_done   = vd;
            res.error_code   = er;
            res.message_done = tok_data.last_byte;
            if (tok_data.last_byte)
            begin
                p = PH_IDLE; d = '0; l = '0; h = '0; s = '0; e = 1'b0; er = ERR_NONE;
            end
            phase_next = p; depth_next = d; left_next = l; lhi_next = h;
            shift_next = s; ek_next = e; err_next = er;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MARKER;
            depth_reg <= '0;
            left_reg  <= '0;
            lhi_reg   <= '0;
            shift_reg <= '0;
            ek_reg    <= 1'b0;
            err_reg   <= ERR_NONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_pop)
            begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                left_reg  <= left_next;
                lhi_reg   <= lhi_next;
                shift_reg <= shift_next;
                ek_reg    <= ek_next;
                err_reg   <= err_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            out_reg <= res;
        end
    end

    `AMF0_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= 5'(MAX_DEPTH),
        "nesting depth above bound")
    `AMF0_ASSERT_IMP(a_err_kind, clk, rst_n, valid_reg,
        (out_reg.byte_kind == KIND_ERROR) == (out_reg.error_code != ERR_NONE),
        "error kind and code disagree")
    `AMF0_ASSERT_NXT(a_last_idle, clk, rst_n, tok_pop && tok_data.last_byte,
        phase_reg == PH_IDLE && depth_reg == '0, "parser not idle after last byte")

endmodule

### rtl/core/amf0_stream_tokenizer_unit.sv
// A result passes through the queue entry and then the parse register.
// Throughput: one byte per cycle while out_stall is low.
// A two-entry queue parts the front classifier from the back parser.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// puts the parser in the expect-marker phase at depth zero.
module amf0_stream_tokenizer_unit #(
    parameter int MAX_DEPTH = amf0_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  amf0_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output amf0_pkg::out_item_t out_data
);
    import amf0_pkg::*;

    logic tok_valid, tok_pop;
    tok_t tok_data;

    amf0_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .tok_valid(tok_valid), .tok_pop(tok_pop), .tok_data(tok_data)
    );

    amf0_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .tok_valid(tok_valid), .tok_pop(tok_pop), .tok_data(tok_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

### dv/tb_amf0_stream_tokenizer_unit.sv
// Testbench for the AMF0 byte tokenizer: drives framed messages, predicts byte roles.
// Depends on amf0_pkg and amf0_stream_tokenizer_unit.
module tb_amf0_stream_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import amf0_pkg::*;

    localparam int DEPTH_LIMIT = MAX_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    class token_scoreboard;
        phase_t      phase;
        logic [4:0]  depth;
        logic [15:0] remaining;
        logic [7:0]  len_hi;
        logic [63:0] num_acc;
        logic        empty_key;
        err_t        err;
        out_item_t   pending[$];
        int          fails;
        int          checked;

        function void clear(phase_t ph);
            phase = ph;
            depth = '0;
            remaining = '0;
            len_hi = '0;
            num_acc = '0;
            empty_key = 1'b0;
            err = ERR_NONE;
        endfunction

        function void init();
            clear(PH_MARKER);
            pending.delete();
            fails = 0;
            checked = 0;
        endfunction

        // Returns 1 when the finished value sat at top level.
        function logic value_end();
            if (depth == 0)
            begin
                phase = PH_MARKER;
                return 1'b1;
            end
            phase = PH_KLEN_HI;
            return 1'b0;
        endfunction

        function void note_byte(in_item_t it);
            out_item_t r;
            logic [7:0] b;
            b = it.data_byte;
            r = '0;
            r.byte_value = b;
            if (it.first_byte)
                clear(PH_MARKER);
            if (phase == PH_IDLE)
            begin
                pending = {pending, r};
                return;
            end
            if (err == ERR_NONE)
            begin
                case (phase)
                    PH_MARKER:
                    begin
                        if (empty_key && b == MARK_OBJ_END)
                        begin
                            r.byte_kind = KIND_OBJ_END;
                            empty_key = 1'b0;
                            if (depth > 0)
                                depth--;
                            r.value_done = value_end();
                        end
                        else
                        begin
                            empty_key = 1'b0;
                            r.byte_kind = KIND_MARKER;
                            if (b == MARK_NUMBER)
                            begin
                                remaining = 8;
                                num_acc = '0;
                                phase = PH_NUM;
                            end
                            else if (b == MARK_BOOLEAN)
                                phase = PH_BOOL;
                            else if (b == MARK_STRING)
                                phase = PH_SLEN_HI;
                            else if (b == MARK_OBJECT)
                            begin
                                if (depth >= DEPTH_LIMIT)
                                    err = ERR_TOO_DEEP;
                                else
                                begin
                                    depth++;
                                    phase = PH_KLEN_HI;
                                end
                            end
                            else if (b == MARK_NULL)
                                r.value_done = value_end();
                            else
                                err = ERR_MARKER;
                        end
                    end
                    PH_NUM:
                    begin
                        r.byte_kind = KIND_NUMBER;
                        num_acc = {num_acc[55:0], b};
                        if (remaining > 0)
                            remaining--;
                        if (remaining == 0)
                        begin
                            r.number_done = 1'b1;
                            r.number_bits = num_acc;
                            r.value_done = value_end();
                        end
                    end
                    PH_BOOL:
                    begin
                        r.byte_kind = KIND_BOOLEAN;
                        r.bool_value = (b != 0);
                        r.value_done = value_end();
                    end
                    PH_SLEN_HI, PH_KLEN_HI:
                    begin
                        r.byte_kind = (phase == PH_SLEN_HI) ? KIND_STR_LEN : KIND_KEY_LEN;
                        len_hi = b;
                        phase = (phase == PH_SLEN_HI) ? PH_SLEN_LO : PH_KLEN_LO;
                    end
                    PH_SLEN_LO:
                    begin
                        r.byte_kind = KIND_STR_LEN;
                        r.field_length = {len_hi, b};
                        if (r.field_length == 0)
                            r.value_done = value_end();
                        else
                        begin
                            remaining = r.field_length;
                            phase = PH_SDATA;
                        end
                    end
                    PH_SDATA:
                    begin
                        r.byte_kind = KIND_STR_DATA;
                        if (remaining > 0)
                            remaining--;
                        if (remaining == 0)
                            r.value_done = value_end();
                    end
                    PH_KLEN_LO:
                    begin
                        r.byte_kind = KIND_KEY_LEN;
                        r.field_length = {len_hi, b};
                        if (r.field_length == 0)
                        begin
                            empty_key = 1'b1;
                            phase = PH_MARKER;
                        end
                        else
                        begin
                            remaining = r.field_length;
                            phase = PH_KDATA;
                        end
                    end
                    PH_KDATA:
                    begin
                        r.byte_kind = KIND_KEY_DATA;
                        if (remaining > 0)
                            remaining--;
                        if (remaining == 0)
                            phase = PH_MARKER;
                    end
                    default:
                        phase = PH_MARKER;
                endcase
            end
            if (it.last_byte && err == ERR_NONE && !(phase == PH_MARKER && depth == 0))
                err = ERR_TRUNCATED;
            r.nest_depth = depth;
            r.error_code = err;
            if (err != ERR_NONE)
            begin
                r.byte_kind = KIND_ERROR;
                r.number_bits = '0;
                r.number_done = 1'b0;
                r.bool_value = 1'b0;
                r.field_length = '0;
                r.value_done = 1'b0;
            end
            r.message_done = it.last_byte;
            if (it.last_byte)
                clear(PH_IDLE);
            pending = {pending, r};
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                fails++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got !== exp)
            begin
                fails++;
                $display("%0t: mismatch expected kind=%0d val=%h dep=%0d num=%h nd=%b bv=%b len=%h vd=%b err=%0d md=%b",
                    $time, exp.byte_kind, exp.byte_value, exp.nest_depth, exp.number_bits,
                    exp.number_done, exp.bool_value, exp.field_length, exp.value_done,
                    exp.error_code, exp.message_done);
                $display("%0t:          actual   kind=%0d val=%h dep=%0d num=%h nd=%b bv=%b len=%h vd=%b err=%0d md=%b",
                    $time, got.byte_kind, got.byte_value, got.nest_depth, got.number_bits,
                    got.number_done, got.bool_value, got.field_length, got.value_done,
                    got.error_code, got.message_done);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    token_scoreboard sb;
    logic      calm;
    int        cycles;
    int        bytes_sent;
    int        messages_sent;

    logic [7:0] msg_buf[$];

    amf0_stream_tokenizer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(negedge clk)
        out_stall <= (!calm && $urandom_range(99) < 8);

    // Send one byte; hold it until accepted. Valid is left high; a later call may drop it.
    task automatic send_byte(logic [7:0] b, logic first, logic last);
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, first_byte: first, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte('{data_byte: b, first_byte: first, last_byte: last});
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_buf.size(); i++)
            send_byte(msg_buf[i], i == 0, i == msg_buf.size() - 1);
        messages_sent++;
        msg_buf.delete();
    endtask

    function void add_byte(logic [7:0] b);
        msg_buf = {msg_buf, b};
    endfunction

    task automatic put_len(int n);
        add_byte(n[15:8]);
        add_byte(n[7:0]);
    endtask

    // Append one well-formed value with random content.
    task automatic put_value(int lvl);
        int sel;
        int n;
        sel = $urandom_range(lvl < 4 ? 5 : 3);
        case (sel)
            0:
            begin
                add_byte(MARK_NUMBER);
                for (int i = 0; i < 8; i++)
                    add_byte(8'($urandom));
            end
            1:
            begin
                add_byte(MARK_BOOLEAN);
                add_byte($urandom_range(3) == 0 ? 8'h00 : 8'($urandom));
            end
            2:
            begin
                add_byte(MARK_STRING);
                n = $urandom_range(5);
                put_len(n);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom));
            end
            3:
                add_byte(MARK_NULL);
            default:
            begin
                add_byte(MARK_OBJECT);
                n = $urandom_range(3);
                for (int k = 0; k < n; k++)
                begin
                    sel = $urandom_range(1, 4);
                    put_len(sel);
                    for (int i = 0; i < sel; i++)
                        add_byte(8'($urandom));
                    put_value(lvl + 1);
                end
                put_len(0);
                add_byte(MARK_OBJ_END);
            end
        endcase
    endtask

    // Drop valid and hold until every expected transaction has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        sb.init();
        calm = 1'b0;
        cycles = 0;
        bytes_sent = 0;
        messages_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Number with extreme bytes, boolean, empty string, null.
        msg_buf = '{MARK_NUMBER, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h7F, 8'hFE};
        send_message();
        msg_buf = '{MARK_BOOLEAN, 8'h00, MARK_BOOLEAN, 8'hFF, MARK_STRING, 8'h00, 8'h00,
                    MARK_NULL};
        send_message();
        // Object with a key and nested object, closed properly.
        msg_buf = '{MARK_OBJECT, 8'h00, 8'h01, 8'h61, MARK_OBJECT, 8'h00, 8'h00,
                    MARK_OBJ_END, 8'h00, 8'h00, MARK_OBJ_END};
        send_message();
        // Unknown marker, sticky error, then a stray end marker.
        msg_buf = '{8'hFF, 8'h00, 8'h01};
        send_message();
        msg_buf = '{MARK_OBJ_END};
        send_message();
        // Truncated string; idle bytes after the message end.
        msg_buf = '{MARK_STRING, 8'h00, 8'h05, 8'h41};
        send_message();
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        // Too deep: seventeen nested objects.
        for (int i = 0; i < DEPTH_LIMIT + 1; i++)
        begin
            add_byte(MARK_OBJECT);
            put_len(0);
        end
        send_message();
        // Large string length, cut short.
        msg_buf = '{MARK_STRING, 8'hFF, 8'hFF, 8'h10, 8'h20};
        send_message();
        wait_drained();

        while (bytes_sent < 1540)
        begin
            int mode;
            calm = (bytes_sent > 800 && bytes_sent < 1000);
            mode = $urandom_range(9);
            if (mode < 7)
            begin
                int nv;
                nv = $urandom_range(1, 3);
                for (int v = 0; v < nv; v++)
                    put_value(0);
                // Occasionally cut a well-formed message short.
                if (mode == 6 && msg_buf.size() > 2)
                    void'(msg_buf.pop_back());
            end
            else if (mode == 7)
            begin
                for (int i = 0; i < $urandom_range(1, 6); i++)
                    add_byte(8'($urandom_range(15)));
            end
            else if (mode == 8)
            begin
                for (int i = 0; i < DEPTH_LIMIT + $urandom_range(1); i++)
                begin
                    add_byte(MARK_OBJECT);
                    put_len(0);
                end
                add_byte(MARK_OBJ_END);
            end
            else
            begin
                send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
                put_value(0);
            end
            if (msg_buf.size() > 0)
                send_message();
            if (messages_sent % 50 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Sent %0d bytes in %0d messages; %0d results checked.",
            bytes_sent, messages_sent, sb.checked);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
